// File: hdl/ofs_pkg.sv
// Shared types and constants for the overview line field splitter.
// No dependencies; imported by every module of the block.
`default_nettype none

package ofs_pkg;

    localparam int MAX_LINE_BYTES_DEF = 65535;
    localparam int FIELD_COUNT_DEF    = 8;
    localparam int QUEUE_DEPTH        = 4;

    localparam int CNT_W   = 4;
    localparam int IDX_W   = 3;
    localparam int OFS_W   = 16;
    localparam int TDATA_W = 48;

    localparam logic [7:0] CHAR_TAB   = 8'h09;
    localparam logic [7:0] CHAR_SPACE = 8'h20;
    localparam logic [7:0] CHAR_LOW   = 8'h22;

    localparam logic KIND_FIELD = 1'b0;
    localparam logic KIND_LINE  = 1'b1;

    // One queue entry: what a single input byte asks the back end to emit.
    typedef struct packed {
        logic             field_valid;
        logic [IDX_W-1:0] field_index;
        logic [OFS_W-1:0] field_start;
        logic [OFS_W-1:0] field_length;
        logic             field_present;
        logic             line_valid;
        logic [CNT_W-1:0] fields_found;
        logic             line_ok;
    } ofs_entry_t;

endpackage

`default_nettype wire

// File: hdl/overview_line_field_splitter_unit.sv
// Overview line field splitter: one line byte per input transaction.
// A byte's results pass the event queue write, then the output register,
// before they are offered on the result stream.
// Front end: one byte per cycle unless the event queue is full. Output register: one
// result per cycle while m_axis_tready is high; a byte that both closes a field and ends the line yields two.
// A 4-entry event queue between parser and emitter absorbs those bursts.
// Reset (rst_n low, asynchronous): line state, queue and output valid clear.
`default_nettype none

module overview_line_field_splitter_unit
    import ofs_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int FIELD_COUNT    = FIELD_COUNT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    // input stream: one byte of the line per transaction
    input  wire logic               s_axis_tvalid,
    output logic                    s_axis_tready,
    input  wire logic [7:0]         s_axis_tdata,   // [7:0] line_byte
    input  wire logic               s_axis_tlast,   // line_end
    // result stream
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,   // [2:0] field_index,
                                                    // [18:3] field_start,
                                                    // [34:19] field_length,
                                                    // [35] field_present,
                                                    // [39:36] fields_found,
                                                    // [40] line_ok, rest zero
    output logic                    m_axis_tlast,   // last_result
    output logic [0:0]              m_axis_tuser    // [0] result_kind
);

    ofs_entry_t push_entry;
    ofs_entry_t head_entry;
    logic       push, full, pop, head_valid, byte_accept;

    // The front end only stalls when the event queue is full.
    assign s_axis_tready = !full;
    assign byte_accept   = s_axis_tvalid && s_axis_tready;

    ofs_front #(
        .MAX_LINE_BYTES (MAX_LINE_BYTES),
        .FIELD_COUNT    (FIELD_COUNT)
    ) u_front (
        .clk         (clk),
        .rst_n       (rst_n),
        .byte_accept (byte_accept),
        .line_byte   (s_axis_tdata),
        .line_end    (s_axis_tlast),
        .push_entry  (push_entry),
        .push        (push)
    );

    ofs_queue #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .full       (full),
        .pop        (pop),
        .head_entry (head_entry),
        .head_valid (head_valid)
    );

    // Emitter: field report first, then the line report for the same byte.
    ofs_back u_back (
        .clk           (clk),
        .rst_n         (rst_n),
        .head_entry    (head_entry),
        .head_valid    (head_valid),
        .pop           (pop),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tlast  (m_axis_tlast),
        .m_axis_tuser  (m_axis_tuser)
    );

endmodule

`default_nettype wire

// File: hdl/ofs_front.sv
// Front end: per-byte line parser (leading space strip, field split, limit).
// Depends on ofs_pkg; pushes field and line events into the queue.
`default_nettype none

module ofs_front
    import ofs_pkg::*;
#(
    parameter int MAX_LINE_BYTES = MAX_LINE_BYTES_DEF,
    parameter int FIELD_COUNT    = FIELD_COUNT_DEF
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       byte_accept,
    input  wire logic [7:0] line_byte,
    input  wire logic       line_end,
    output ofs_entry_t      push_entry,
    output logic            push
);

    localparam int POS_W = $clog2(MAX_LINE_BYTES + 1);
    localparam int EXT_W = (POS_W > OFS_W) ? POS_W : OFS_W;

    localparam logic [1:0] PH_LEAD  = 2'd0;
    localparam logic [1:0] PH_FIELD = 2'd1;
    localparam logic [1:0] PH_SKIP  = 2'd2;
    localparam logic [1:0] PH_DONE  = 2'd3;

    logic [1:0]       phase_reg, phase_next;
    logic [CNT_W-1:0] count_reg, count_next;
    logic [POS_W-1:0] pos_reg, pos_next;
    logic [POS_W-1:0] start_reg, start_next;
    logic [POS_W-1:0] len_reg, len_next;
    logic             ovf_reg, ovf_next;

    logic             at_limit, is_tab, is_space, enter, in_field, tab_hit;
    logic [POS_W-1:0] cur_start, cur_len;
    logic [EXT_W-1:0] start_ext, len_ext;
    logic [CNT_W-1:0] count_step;

    always_comb
    begin
        at_limit = (pos_reg >= POS_W'(MAX_LINE_BYTES));
        is_tab   = (line_byte == CHAR_TAB);
        is_space = (line_byte == CHAR_SPACE);
        enter    = ((phase_reg == PH_LEAD) && !is_space) ||
                   ((phase_reg == PH_SKIP) && ((line_byte >= CHAR_LOW) || is_tab));
        in_field = (phase_reg == PH_FIELD) || enter;
        cur_start = enter ? pos_reg : start_reg;
        cur_len   = enter ? '0 : len_reg;
        tab_hit   = !at_limit && in_field && is_tab;
        count_step = tab_hit ? count_reg + CNT_W'(1) : count_reg;

        start_ext = EXT_W'(cur_start);
        len_ext   = EXT_W'(cur_len);

        push_entry.field_valid   = tab_hit;
        push_entry.field_index   = count_reg[IDX_W-1:0];
        push_entry.field_present = (cur_len != '0);
        push_entry.field_start   = (cur_len != '0) ? start_ext[OFS_W-1:0] : '0;
        push_entry.field_length  = (len_ext > EXT_W'(16'hFFFF)) ? 16'hFFFF
                                                               : len_ext[OFS_W-1:0];
        push_entry.line_valid    = line_end;
        push_entry.fields_found  = count_step;
        push_entry.line_ok       = (count_step == CNT_W'(FIELD_COUNT)) &&
                                   !ovf_reg && !at_limit;
        push = byte_accept && (tab_hit || line_end);

        phase_next = phase_reg;
        count_next = count_reg;
        pos_next   = pos_reg;
        start_next = start_reg;
        len_next   = len_reg;
        ovf_next   = ovf_reg;

        if (byte_accept)
        begin
            if (at_limit)
            begin
                ovf_next = 1'b1;
            end
            else
            begin
                pos_next   = pos_reg + POS_W'(1);
                count_next = count_step;
                if (in_field)
                begin
                    phase_next = PH_FIELD;
                    start_next = cur_start;
                    if (is_tab)
                    begin
                        len_next = '0;
                        if (count_step >= CNT_W'(FIELD_COUNT))
                            phase_next = PH_DONE;
                        else if (count_step == CNT_W'(1))
                            phase_next = PH_SKIP;
                        else
                            start_next = pos_reg + POS_W'(1);
                    end
                    else
                    begin
                        len_next = cur_len + POS_W'(1);
                    end
                end
            end

            // line end: every piece of line state goes back to its reset value
            if (line_end)
            begin
                phase_next = PH_LEAD;
                count_next = '0;
                pos_next   = '0;
                start_next = '0;
                len_next   = '0;
                ovf_next   = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            phase_reg <= PH_LEAD;
            count_reg <= '0;
            pos_reg   <= '0;
            start_reg <= '0;
            len_reg   <= '0;
            ovf_reg   <= 1'b0;
        end
        else
        begin
            phase_reg <= phase_next;
            count_reg <= count_next;
            pos_reg   <= pos_next;
            start_reg <= start_next;
            len_reg   <= len_next;
            ovf_reg   <= ovf_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ofs_queue.sv
// Short register FIFO of parser events between front and back end.
// Depends on ofs_pkg for the entry type.
`default_nettype none

module ofs_queue
    import ofs_pkg::*;
#(
    parameter int DEPTH = QUEUE_DEPTH
)
(
    input  wire logic       clk,
    input  wire logic       rst_n,
    input  wire logic       push,
    input  ofs_entry_t      push_entry,
    output logic            full,
    input  wire logic       pop,
    output ofs_entry_t      head_entry,
    output logic            head_valid
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_QW = $clog2(DEPTH + 1);

    ofs_entry_t        slot_reg [DEPTH];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_QW-1:0] fill_reg, fill_next;
    logic              do_push, do_pop;

    always_comb
    begin
        full       = (fill_reg == CNT_QW'(DEPTH));
        head_valid = (fill_reg != '0);
        head_entry = slot_reg[rd_ptr_reg];
        do_push    = push && !full;
        do_pop     = pop && head_valid;

        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        if (do_push)
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        if (do_pop)
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);

        fill_next = fill_reg;
        if (do_push && !do_pop)
            fill_next = fill_reg + CNT_QW'(1);
        else if (do_pop && !do_push)
            fill_next = fill_reg - CNT_QW'(1);
    end

    always_ff @(posedge clk)
    begin
        if (do_push)
            slot_reg[wr_ptr_reg] <= push_entry;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            fill_reg   <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            fill_reg   <= fill_next;
        end
    end

endmodule

`default_nettype wire

// File: hdl/ofs_back.sv
// Back end: turns queue entries into output transactions through a register.
// Depends on ofs_pkg; one entry yields a field report, a line report or both.
`default_nettype none

module ofs_back
    import ofs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  ofs_entry_t              head_entry,
    input  wire logic               head_valid,
    output logic                    pop,
    output logic                    m_axis_tvalid,
    input  wire logic               m_axis_tready,
    output logic [TDATA_W-1:0]      m_axis_tdata,
    output logic                    m_axis_tlast,
    output logic [0:0]              m_axis_tuser
);

    logic               sent_reg, sent_next;
    logic               valid_reg, valid_next;
    logic [TDATA_W-1:0] data_reg, data_next;
    logic               last_reg, last_next;
    logic               kind_reg, kind_next;
    logic               load;

    always_comb
    begin
        load      = head_valid && (!valid_reg || m_axis_tready);
        pop       = 1'b0;
        sent_next = sent_reg;
        data_next = data_reg;
        last_next = last_reg;
        kind_next = kind_reg;

        if (load)
        begin
            if (head_entry.field_valid && !sent_reg)
            begin
                kind_next = KIND_FIELD;
                last_next = !head_entry.line_valid;
                data_next = {7'd0, 1'b0, 4'd0, head_entry.field_present,
                             head_entry.field_length, head_entry.field_start,
                             head_entry.field_index};
                if (head_entry.line_valid)
                    sent_next = 1'b1;
                else
                    pop = 1'b1;
            end
            else
            begin
                kind_next = KIND_LINE;
                last_next = 1'b1;
                data_next = {7'd0, head_entry.line_ok, head_entry.fields_found,
                             1'b0, 16'd0, 16'd0, 3'd0};
                pop       = 1'b1;
                sent_next = 1'b0;
            end
        end

        valid_next = load ? 1'b1 : (valid_reg && !m_axis_tready);
    end

    always_ff @(posedge clk)
    begin
        data_reg <= data_next;
        last_reg <= last_next;
        kind_reg <= kind_next;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
            sent_reg  <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
            sent_reg  <= sent_next;
        end
    end

    assign m_axis_tvalid   = valid_reg;
    assign m_axis_tdata    = data_reg;
    assign m_axis_tlast    = last_reg;
    assign m_axis_tuser[0] = kind_reg;

endmodule

`default_nettype wire

// File: hdl/ofs_checker.sv
// Port-level checker for the overview line field splitter, bound to the top.
// Depends on ofs_pkg for widths and the default field count.
`default_nettype none

module ofs_checker
    import ofs_pkg::*;
#(
    parameter int FIELD_COUNT = FIELD_COUNT_DEF
)
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               m_axis_tvalid,
    input  wire logic               m_axis_tready,
    input  wire logic [TDATA_W-1:0] m_axis_tdata,
    input  wire logic               m_axis_tlast,
    input  wire logic [0:0]         m_axis_tuser
);

    // a stalled result transaction stays offered
    a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && !m_axis_tready |=> m_axis_tvalid)
        else $error("result transaction dropped while stalled");

    // a line report always closes the results of its byte
    a_line_last: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_LINE) |-> m_axis_tlast)
        else $error("line report without last_result");

    // field_present agrees with the reported length
    a_present: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_FIELD) |->
            (m_axis_tdata[35] == (m_axis_tdata[34:19] != 16'd0)))
        else $error("field_present disagrees with field_length");

    // a good line has every field counted
    a_ok_count: assert property (@(posedge clk) disable iff (!rst_n)
        m_axis_tvalid && (m_axis_tuser[0] == KIND_LINE) && m_axis_tdata[40] |->
            (m_axis_tdata[39:36] == CNT_W'(FIELD_COUNT)))
        else $error("line_ok with wrong fields_found");

endmodule

bind overview_line_field_splitter_unit ofs_checker #(
    .FIELD_COUNT (FIELD_COUNT)
) u_ofs_checker (
    .clk           (clk),
    .rst_n         (rst_n),
    .m_axis_tvalid (m_axis_tvalid),
    .m_axis_tready (m_axis_tready),
    .m_axis_tdata  (m_axis_tdata),
    .m_axis_tlast  (m_axis_tlast),
    .m_axis_tuser  (m_axis_tuser)
);

`default_nettype wire

// File: sim/ofs_split_checker.sv
`timescale 1ns / 100ps
// Result checker for the overview line field splitter: predicts field and line reports.
// Depends on ofs_pkg; watches both stream channels of the unit, never drives them.

module ofs_split_checker
    import ofs_pkg::*;
(
    input  wire logic               clk,
    input  wire logic               rst_n,
    input  wire logic               s_tvalid,
    input  wire logic               s_tready,
    input  wire logic [7:0]         s_tdata,
    input  wire logic               s_tlast,
    input  wire logic               m_tvalid,
    input  wire logic               m_tready,
    input  wire logic [TDATA_W-1:0] m_tdata,
    input  wire logic               m_tlast,
    input  wire logic [0:0]         m_tuser,
    output int                      error_count,
    output int                      pending
);

    typedef enum logic [1:0] {SEEK_TEXT, IN_FIELD, SKIP_LOW, ALL_DONE} split_phase_t;

    typedef struct packed {
        logic             kind;
        logic [IDX_W-1:0] index;
        logic [OFS_W-1:0] start;
        logic [OFS_W-1:0] length;
        logic             present;
        logic [CNT_W-1:0] found;
        logic             ok;
        logic             last;
    } split_report_t;

    split_report_t expected_reports[$];

    // line state of the prediction
    split_phase_t phase;
    int unsigned  fields_done;
    int unsigned  line_pos;
    int unsigned  field_begin;
    int unsigned  field_len;
    bit           too_long;

    initial begin
        error_count = 0;
        pending     = 0;
        phase       = SEEK_TEXT;
        fields_done = 0;
        line_pos    = 0;
        field_begin = 0;
        field_len   = 0;
        too_long    = 1'b0;
    end

    task automatic report_error(input string what, input logic [31:0] got,
                                input logic [31:0] want);
        error_count++;
        if (error_count <= 30)
            $display("ERROR %0t: %s got %0h want %0h", $time, what, got, want);
    endtask

    // Works out the reports that one line byte causes.
    task automatic split_byte(input logic [7:0] b, input logic eol);
        split_report_t r;
        int unsigned   pos;
        if (line_pos >= MAX_LINE_BYTES_DEF) begin
            too_long = 1'b1;
        end else begin
            pos = line_pos;
            line_pos++;
            if (phase == SEEK_TEXT) begin
                if (b != CHAR_SPACE) begin
                    phase       = IN_FIELD;
                    field_begin = pos;
                    field_len   = 0;
                end
            end else if (phase == SKIP_LOW) begin
                if (b >= CHAR_LOW || b == CHAR_TAB) begin
                    phase       = IN_FIELD;
                    field_begin = pos;
                    field_len   = 0;
                end
            end
            if (phase == IN_FIELD) begin
                if (b == CHAR_TAB) begin
                    r         = '0;
                    r.kind    = KIND_FIELD;
                    r.index   = fields_done[IDX_W-1:0];
                    r.present = (field_len > 0);
                    r.start   = r.present ? field_begin[OFS_W-1:0] : '0;
                    r.length  = (field_len > 32'hFFFF) ? 16'hFFFF : field_len[OFS_W-1:0];
                    r.last    = !eol;
                    expected_reports.push_back(r);
                    fields_done++;
                    if (fields_done >= FIELD_COUNT_DEF) begin
                        phase = ALL_DONE;
                    end else if (fields_done == 1) begin
                        // first field closed: low control bytes get skipped now
                        phase = SKIP_LOW;
                    end else begin
                        field_begin = pos + 1;
                        field_len   = 0;
                    end
                end else begin
                    field_len++;
                end
            end
        end
        if (eol) begin
            r       = '0;
            r.kind  = KIND_LINE;
            r.found = fields_done[CNT_W-1:0];
            r.ok    = (fields_done == FIELD_COUNT_DEF) && !too_long;
            r.last  = 1'b1;
            expected_reports.push_back(r);
            phase       = SEEK_TEXT;
            fields_done = 0;
            line_pos    = 0;
            field_begin = 0;
            field_len   = 0;
            too_long    = 1'b0;
        end
    endtask

    task automatic compare_report(input split_report_t want);
        if (m_tuser[0] !== want.kind)
            report_error("result_kind", 32'(m_tuser[0]), 32'(want.kind));
        if (m_tdata[2:0] !== want.index)
            report_error("field_index", 32'(m_tdata[2:0]), 32'(want.index));
        if (m_tdata[18:3] !== want.start)
            report_error("field_start", 32'(m_tdata[18:3]), 32'(want.start));
        if (m_tdata[34:19] !== want.length)
            report_error("field_length", 32'(m_tdata[34:19]), 32'(want.length));
        if (m_tdata[35] !== want.present)
            report_error("field_present", 32'(m_tdata[35]), 32'(want.present));
        if (m_tdata[39:36] !== want.found)
            report_error("fields_found", 32'(m_tdata[39:36]), 32'(want.found));
        if (m_tdata[40] !== want.ok)
            report_error("line_ok", 32'(m_tdata[40]), 32'(want.ok));
        if (m_tlast !== want.last)
            report_error("last_result", 32'(m_tlast), 32'(want.last));
        if (m_tdata[TDATA_W-1:41] !== '0)
            report_error("tdata padding", 32'(m_tdata[TDATA_W-1:41]), 0);
    endtask

    // Both channels sampled at the edge, before any driver update lands.
    always @(posedge clk) begin
        if (rst_n) begin
            if (s_tvalid && s_tready)
                split_byte(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_reports.size() == 0)
                    report_error("result with nothing expected", m_tdata[31:0], 0);
                else
                    compare_report(expected_reports.pop_front());
            end
        end
        pending = expected_reports.size();
    end

endmodule

// File: sim/tb_top.sv
`timescale 1ns / 100ps
// Top of the splitter testbench: clock, reset, byte stimulus and verdict.
// Depends on ofs_pkg, overview_line_field_splitter_unit and ofs_split_checker.

module tb_top;
    import ofs_pkg::*;

    localparam int RX_HOLD_CYCLES = 300;   // long receiver hold-off, fills the event queue
    localparam int DRAIN_CYCLES   = 8;     // extra wait after the last report is back
    localparam int RANDOM_ITEMS   = 1300;

    logic               clk   = 1'b0;
    logic               rst_n = 1'b0;
    logic               s_tvalid = 1'b0;
    logic               s_tready;
    logic [7:0]         s_tdata  = 8'h00;  // [7:0] line_byte
    logic               s_tlast  = 1'b0;   // line_end
    logic               m_tvalid;
    logic               m_tready = 1'b0;
    logic [TDATA_W-1:0] m_tdata;           // [2:0] index, [18:3] start, [34:19] length,
                                           // [35] present, [39:36] found, [40] ok
    logic               m_tlast;           // last_result
    logic [0:0]         m_tuser;           // [0] result_kind

    int   error_count;
    int   pending;
    int   tx_idle_pct  = 0;
    int   rx_stall_pct = 0;
    bit   hold_pending = 1'b0;
    int   random_items = 0;

    logic [7:0] line_buf[$];

    always
    begin
        #6 clk = 1'b1;
        #6 clk = 1'b0;
    end

    overview_line_field_splitter_unit uut
    (
        .clk           (clk),
        .rst_n         (rst_n),
        .s_axis_tvalid (s_tvalid),
        .s_axis_tready (s_tready),
        .s_axis_tdata  (s_tdata),
        .s_axis_tlast  (s_tlast),
        .m_axis_tvalid (m_tvalid),
        .m_axis_tready (m_tready),
        .m_axis_tdata  (m_tdata),
        .m_axis_tlast  (m_tlast),
        .m_axis_tuser  (m_tuser)
    );

    ofs_split_checker u_checker
    (
        .clk         (clk),
        .rst_n       (rst_n),
        .s_tvalid    (s_tvalid),
        .s_tready    (s_tready),
        .s_tdata     (s_tdata),
        .s_tlast     (s_tlast),
        .m_tvalid    (m_tvalid),
        .m_tready    (m_tready),
        .m_tdata     (m_tdata),
        .m_tlast     (m_tlast),
        .m_tuser     (m_tuser),
        .error_count (error_count),
        .pending     (pending)
    );

    // Receiver: random backpressure, or a long counted hold-off on request.
    initial
    begin
        forever
        begin
            @(posedge clk);
            if (hold_pending)
            begin
                hold_pending = 1'b0;
                m_tready <= 1'b0;
                repeat (RX_HOLD_CYCLES) @(posedge clk);
            end
            else
            begin
                m_tready <= ($urandom_range(99) >= rx_stall_pct);
            end
        end
    end

    // 0: no idling, 1: sender gaps, 2: receiver stalls, 3: both, lighter
    task automatic set_idle_mode(input int mode);
        case (mode)
            1:       begin tx_idle_pct = 47; rx_stall_pct = 0;  end
            2:       begin tx_idle_pct = 0;  rx_stall_pct = 47; end
            3:       begin tx_idle_pct = 16; rx_stall_pct = 16; end
            default: begin tx_idle_pct = 0;  rx_stall_pct = 0;  end
        endcase
    endtask

    // One byte transaction; called at a rising edge, returns at the accepting edge.
    task automatic send_byte(input logic [7:0] b, input logic eol);
        while ($urandom_range(99) < tx_idle_pct)
        begin
            s_tvalid <= 1'b0;
            @(posedge clk);
        end
        s_tvalid <= 1'b1;
        s_tdata  <= b;
        s_tlast  <= eol;
        @(posedge clk);
        while (!s_tready) @(posedge clk);
    endtask

    task automatic send_line();
        foreach (line_buf[i])
            send_byte(line_buf[i], i == line_buf.size() - 1);
        line_buf.delete();
    endtask

    task automatic stop_sending();
        s_tvalid <= 1'b0;
    endtask

    // Sender pause until every report is back; resumes on a rising edge.
    task automatic wait_drained();
        stop_sending();
        @(negedge clk);
        while (pending != 0) @(negedge clk);
        @(posedge clk);
    endtask

    function automatic logic [7:0] text_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, 255));
        if (b == CHAR_TAB)
            b = 8'hA9;
        return b;
    endfunction

    // control byte that the skip after the first field drops
    function automatic logic [7:0] low_byte();
        logic [7:0] b;
        b = 8'($urandom_range(0, CHAR_LOW - 1));
        if (b == CHAR_TAB)
            b = 8'h00;
        return b;
    endfunction

    task automatic push_field(input int len);
        repeat (len) line_buf.push_back(text_byte());
        line_buf.push_back(CHAR_TAB);
    endtask

    // Eight tab-terminated fields with random content and optional garbage.
    task automatic build_good_line();
        int max_len;
        max_len = ($urandom_range(9) == 0) ? 40 : 5;
        repeat ($urandom_range(0, 3) == 0 ? $urandom_range(1, 3) : 0)
            line_buf.push_back(CHAR_SPACE);
        for (int f = 0; f < FIELD_COUNT_DEF; f++)
        begin
            if (f == 1)
                repeat ($urandom_range(0, 2)) line_buf.push_back(low_byte());
            push_field($urandom_range(0, max_len));
        end
        repeat ($urandom_range(0, 1) == 0 ? 0 : $urandom_range(1, 4))
            line_buf.push_back(8'($urandom_range(0, 255)));
    endtask

    task automatic build_random_line();
        int pick;
        pick = $urandom_range(99);
        if (pick < 70)
        begin
            build_good_line();
        end
        else if (pick < 82)
        begin
            // cut short: missing tabs or an open field at line end
            build_good_line();
            repeat ($urandom_range(1, line_buf.size() - 1)) void'(line_buf.pop_back());
        end
        else if (pick < 88)
        begin
            repeat ($urandom_range(1, 4)) line_buf.push_back(CHAR_SPACE);
        end
        else
        begin
            repeat ($urandom_range(1, 20))
                line_buf.push_back(($urandom_range(3) == 0) ? CHAR_TAB
                                                            : 8'($urandom_range(0, 255)));
        end
    endtask

    initial
    begin
        int line_no;
        repeat (10) @(posedge clk);
        rst_n <= 1'b1;
        set_idle_mode(0);

        // --- directed lines ---
        // only spaces: fails with no fields
        repeat (3) line_buf.push_back(CHAR_SPACE);
        send_line();
        // single byte, field left open
        line_buf.push_back(8'hFF);
        send_line();
        // tab that ends the line: field report then line report
        line_buf.push_back(CHAR_TAB);
        send_line();
        // eight empty fields, last tab ends the line
        repeat (FIELD_COUNT_DEF) line_buf.push_back(CHAR_TAB);
        send_line();
        // leading space, low bytes skipped after the first field, trailing bytes ignored
        line_buf = '{CHAR_SPACE, 8'h41, CHAR_TAB, 8'h01, CHAR_SPACE, 8'h42, CHAR_TAB};
        repeat (FIELD_COUNT_DEF - 2) line_buf.push_back(CHAR_TAB);
        line_buf.push_back(8'h7F);
        line_buf.push_back(CHAR_TAB);
        line_buf.push_back(8'h80);
        send_line();
        // missing tab on the third field
        line_buf = '{8'h61, CHAR_TAB, 8'h62, CHAR_TAB, 8'h63};
        send_line();

        // --- pressure: receiver holds off while the sender keeps offering ---
        wait_drained();
        @(negedge clk);
        hold_pending = 1'b1;
        @(posedge clk);
        repeat (4)
        begin
            build_good_line();
            random_items += line_buf.size();
            send_line();
        end

        // --- random lines, idle mode rotating every few lines ---
        line_no = 0;
        while (random_items < RANDOM_ITEMS)
        begin
            set_idle_mode((line_no / 4) % 4);
            build_random_line();
            random_items += line_buf.size();
            send_line();
            line_no++;
            if (line_no % 10 == 0)
                wait_drained();
        end

        wait_drained();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (error_count == 0)
            $display("overview_line_field_splitter_unit: match");
        else
            $display("overview_line_field_splitter_unit: mismatch");
        $finish;
    end

    // hard limit, far above the slowest passing run
    initial
    begin
        #25_000_000;
        $display("overview_line_field_splitter_unit: mismatch");
        $finish;
    end

endmodule
